// ===== rtl/nwi_pkg.sv =====
// shared constants, types and saturation helpers for the newton interpolator
// no dependencies; imported by every rtl file of the block
`timescale 1ns / 1ps

package nwi_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 16;
  localparam int CFG_W      = 5;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DVD_W      = DATA_W + FRAC_BITS;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int MUL_CNT_W  = $clog2(DATA_W);

  localparam logic [CFG_W-1:0]  COUNT_RESET = CFG_W'(4);
  localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIV_ZERO  = 2'd1,
    ST_SAT       = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLD_RD,
    S_BLD_DIF,
    S_BLD_DIV,
    S_BLD_WR,
    S_QRY_C0,
    S_QRY_INIT,
    S_QRY_J,
    S_QRY_JD,
    S_QRY_RD,
    S_QRY_DIF,
    S_QRY_MUL,
    S_QRY_ACC,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } sat_val_t;

  // clamp a one-bit-grown sum or difference back to the signed range
  function automatic sat_val_t clamp_grown(input logic [DATA_W:0] d);
    sat_val_t r;
    r.sat = (d[DATA_W] != d[DATA_W-1]);
    if (r.sat) begin
      r.value = d[DATA_W] ? S_MIN : S_MAX;
    end else begin
      r.value = d[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_val_t sat_sub(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
    return clamp_grown({a[DATA_W-1], a} - {b[DATA_W-1], b});
  endfunction

  function automatic sat_val_t sat_add(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
    return clamp_grown({a[DATA_W-1], a} + {b[DATA_W-1], b});
  endfunction

  // node count clamped to 1..MAX_POINTS
  function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] pc);
    logic [CNT_W-1:0] n;
    if (pc == '0) begin
      n = CNT_W'(1);
    end else if (int'(pc) > MAX_POINTS) begin
      n = CNT_W'(MAX_POINTS);
    end else begin
      n = CNT_W'(pc);
    end
    return n;
  endfunction

endpackage

// ===== rtl/nwi_div.sv =====
// bit-serial signed fixed-point divider, one quotient bit per cycle
// depends on nwi_pkg; quotient truncates toward zero and saturates
`timescale 1ns / 1ps

module nwi_div import nwi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              done,
  output logic [DATA_W-1:0] quot,
  output logic              sat
);

  logic                 busy;
  logic                 fin;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    dmag;
  logic [DATA_W-1:0]    rem;
  logic [DVD_W-1:0]     dvd;

  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic                 ge;
  logic [DATA_W-1:0]    nmag;
  logic [DATA_W-1:0]    dmag_in;
  logic [DVD_W-1:0]     lim;

  assign trial   = {rem, dvd[DVD_W-1]};
  assign diff    = trial - {1'b0, dmag};
  assign ge      = (trial >= {1'b0, dmag});
  assign nmag    = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign dmag_in = den[DATA_W-1] ? (~den + 1'b1) : den;
  assign lim     = DVD_W'(S_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DVD_W - 1);
        neg  <= num[DATA_W-1] ^ den[DATA_W-1];
        dmag <= dmag_in;
        rem  <= '0;
        dvd  <= {nmag, {FRAC_BITS{1'b0}}};
      end else if (busy) begin
        rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        dvd <= {dvd[DVD_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // sign and clamp of the finished magnitude
  always_ff @(posedge clk) begin
    if (fin) begin
      if (neg) begin
        sat  <= (dvd > lim);
        quot <= (dvd > lim) ? S_MIN : (~dvd[DATA_W-1:0] + 1'b1);
      end else begin
        sat  <= (dvd >= lim);
        quot <= (dvd >= lim) ? S_MAX : dvd[DATA_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/nwi_mul.sv =====
// bit-serial signed fixed-point multiplier, one multiplier bit per cycle
// depends on nwi_pkg; product floors to the fraction grid and saturates
`timescale 1ns / 1ps

module nwi_mul import nwi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic              done,
  output logic [DATA_W-1:0] prod,
  output logic              sat
);

  logic                 busy;
  logic                 fin;
  logic [MUL_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    mcand;
  logic [DATA_W-1:0]    hi;
  logic [DATA_W-1:0]    lo;

  logic [DATA_W:0]      mext;
  logic [DATA_W:0]      addend;
  logic [DATA_W:0]      sum;
  logic [PROD_W-1:0]    full;
  logic [DVD_W-1:0]     shifted;
  logic                 over;

  assign mext = {mcand[DATA_W-1], mcand};
  // the sign bit of the multiplier weighs negative
  always_comb begin
    if (!lo[0]) begin
      addend = '0;
    end else if (cnt == '0) begin
      addend = ~mext + 1'b1;
    end else begin
      addend = mext;
    end
  end
  assign sum     = {hi[DATA_W-1], hi} + addend;
  assign full    = {hi, lo};
  assign shifted = full[PROD_W-1:FRAC_BITS];
  assign over    = (shifted[DVD_W-1:DATA_W-1] != '0) &&
                   (shifted[DVD_W-1:DATA_W-1] != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= MUL_CNT_W'(DATA_W - 1);
        mcand <= a;
        hi    <= '0;
        lo    <= b;
      end else if (busy) begin
        hi <= sum[DATA_W:1];
        lo <= {sum[0], lo[DATA_W-1:1]};
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      sat  <= over;
      prod <= over ? (shifted[DVD_W-1] ? S_MIN : S_MAX) : shifted[DATA_W-1:0];
    end
  end

endmodule

// ===== rtl/newton_interpolator.sv =====
// top level: node stores, coefficient build and query sequencer
// depends on nwi_pkg, nwi_div and nwi_mul
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  input    | in_valid / in_stall  | command, x_value, y_value
//  output   | out_valid / out_stall| interpolated, status
//  config   | cfg_write            | cfg_data (point_count)
//
// clear and unused commands, and every load but the one that completes the
// node set, keep the block idle. the load that completes the node set starts
// the coefficient build: n(n-1)/2 quotient steps on the one-bit-per-cycle
// divider, each skipped and written as zero when its denominator is zero.
// a query runs n(n-1)/2 products on the one-bit-per-cycle multiplier;
// not-ready and fault answers go straight to the result without computing.
// synchronous reset clears control state; node stores hold garbage until loaded.
// a finished result waits in the output register under out_stall while the
// next transaction is taken in.

module newton_interpolator import nwi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [DATA_W-1:0] x_value,
  input  logic [DATA_W-1:0] y_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] interpolated,
  output logic [1:0]        status,
  input  logic              cfg_write,
  input  logic [CFG_W-1:0]  cfg_data
);

  // node and coefficient memories, two registered read ports each
  logic [DATA_W-1:0] node_x [MAX_POINTS];
  logic [DATA_W-1:0] coef   [MAX_POINTS];
  logic [DATA_W-1:0] x_rd_a, x_rd_b, c_rd_a, c_rd_b;
  logic [IDX_W-1:0]  x_ra_a, x_ra_b, c_ra_a, c_ra_b;
  logic              x_we, c_we;
  logic [IDX_W-1:0]  x_wa, c_wa;
  logic [DATA_W-1:0] c_wd;

  // control and working registers
  state_t            state, state_next;
  logic [CFG_W-1:0]  point_count;
  logic [CNT_W-1:0]  loaded_count, loaded_count_next;
  logic              ready, ready_next;
  logic              fault, fault_next;
  logic              build_sat, build_sat_next;
  logic [IDX_W-1:0]  j, j_next, k, k_next;
  logic [DATA_W-1:0] xq, xq_next;
  logic [DATA_W-1:0] acc, acc_next;
  logic [DATA_W-1:0] term, term_next;
  logic              qsat, qsat_next;
  logic [DATA_W-1:0] wval, wval_next;
  logic [DATA_W-1:0] res_val, res_val_next;
  status_t           res_st, res_st_next;
  logic              out_valid_next;

  logic [CNT_W-1:0]  n;
  logic [IDX_W-1:0]  n_m1;
  logic              accept;
  logic              load_do;
  logic              out_free;
  sat_val_t          num_s, den_s, d_s, acc_s;

  logic              div_start, div_done, div_sat;
  logic [DATA_W-1:0] div_q;
  logic              mul_start, mul_done, mul_sat;
  logic [DATA_W-1:0] mul_p;

  assign n        = eff_count(point_count);
  assign n_m1     = IDX_W'(n - 1'b1);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_do  = accept && (command == CMD_LOAD) && !ready && (loaded_count < n);
  assign out_free = !out_valid || !out_stall;

  // read addresses by phase
  assign c_ra_a = (state == S_QRY_C0) ? '0 : ((state == S_QRY_J) ? j : k);
  assign c_ra_b = k - 1'b1;
  assign x_ra_a = (state == S_BLD_RD) ? k : (k - 1'b1);
  assign x_ra_b = k - j;

  // load writes both stores; the build rewrites coefficients in place
  assign x_we = load_do;
  assign x_wa = loaded_count[IDX_W-1:0];
  assign c_we = load_do || (state == S_BLD_WR);
  assign c_wa = load_do ? loaded_count[IDX_W-1:0] : k;
  assign c_wd = load_do ? y_value : wval;

  always_ff @(posedge clk) begin
    if (x_we) begin
      node_x[x_wa] <= x_value;
    end
    if (c_we) begin
      coef[c_wa] <= c_wd;
    end
    x_rd_a <= node_x[x_ra_a];
    x_rd_b <= node_x[x_ra_b];
    c_rd_a <= coef[c_ra_a];
    c_rd_b <= coef[c_ra_b];
  end

  assign num_s = sat_sub(c_rd_a, c_rd_b);
  assign den_s = sat_sub(x_rd_a, x_rd_b);
  assign d_s   = sat_sub(xq, x_rd_a);
  assign acc_s = sat_add(acc, term);

  nwi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_s.value),
    .den   (den_s.value),
    .done  (div_done),
    .quot  (div_q),
    .sat   (div_sat)
  );

  nwi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (term),
    .b     (d_s.value),
    .done  (mul_done),
    .prod  (mul_p),
    .sat   (mul_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= COUNT_RESET;
      loaded_count <= '0;
      ready        <= 1'b0;
      fault        <= 1'b0;
      build_sat    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      loaded_count <= loaded_count_next;
      ready        <= ready_next;
      fault        <= fault_next;
      build_sat    <= build_sat_next;
      out_valid    <= out_valid_next;
      if (cfg_write) begin
        point_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    j       <= j_next;
    k       <= k_next;
    xq      <= xq_next;
    acc     <= acc_next;
    term    <= term_next;
    qsat    <= qsat_next;
    wval    <= wval_next;
    res_val <= res_val_next;
    res_st  <= res_st_next;
    if (state == S_RESULT && out_free) begin
      interpolated <= res_val;
      status       <= res_st;
    end
  end

  always_comb begin
    state_next        = state;
    loaded_count_next = loaded_count;
    ready_next        = ready;
    fault_next        = fault;
    build_sat_next    = build_sat;
    j_next            = j;
    k_next            = k;
    xq_next           = xq;
    acc_next          = acc;
    term_next         = term;
    qsat_next         = qsat;
    wval_next         = wval;
    res_val_next      = res_val;
    res_st_next       = res_st;
    out_valid_next    = out_valid && out_stall;
    div_start         = 1'b0;
    mul_start         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_LOAD: begin
              if (load_do) begin
                loaded_count_next = loaded_count + 1'b1;
                // last node in: start the divided differences, or go ready for a single node
                if (loaded_count + 1'b1 >= n) begin
                  if (n == CNT_W'(1)) begin
                    ready_next = 1'b1;
                  end else begin
                    j_next     = IDX_W'(1);
                    k_next     = n_m1;
                    state_next = S_BLD_RD;
                  end
                end
              end
            end
            CMD_QUERY: begin
              xq_next      = x_value;
              res_val_next = '0;
              if (!ready) begin
                res_st_next = ST_NOT_READY;
                state_next  = S_RESULT;
              end else if (fault) begin
                res_st_next = ST_DIV_ZERO;
                state_next  = S_RESULT;
              end else begin
                qsat_next  = build_sat;
                state_next = S_QRY_C0;
              end
            end
            CMD_CLEAR: begin
              loaded_count_next = '0;
              ready_next        = 1'b0;
              fault_next        = 1'b0;
              build_sat_next    = 1'b0;
            end
            default: begin
            end
          endcase
        end
        if (cfg_write) begin
          loaded_count_next = '0;
          ready_next        = 1'b0;
          fault_next        = 1'b0;
          build_sat_next    = 1'b0;
        end
      end

      S_BLD_RD: begin
        state_next = S_BLD_DIF;
      end

      S_BLD_DIF: begin
        build_sat_next = build_sat | num_s.sat | den_s.sat;
        if (den_s.value == '0) begin
          fault_next = 1'b1;
          wval_next  = '0;
          state_next = S_BLD_WR;
        end else begin
          div_start  = 1'b1;
          state_next = S_BLD_DIV;
        end
      end

      S_BLD_DIV: begin
        if (div_done) begin
          wval_next      = div_q;
          build_sat_next = build_sat | div_sat;
          state_next     = S_BLD_WR;
        end
      end

      S_BLD_WR: begin
        if (k == j) begin
          if (j == n_m1) begin
            ready_next = 1'b1;
            state_next = S_IDLE;
          end else begin
            j_next     = j + 1'b1;
            k_next     = n_m1;
            state_next = S_BLD_RD;
          end
        end else begin
          k_next     = k - 1'b1;
          state_next = S_BLD_RD;
        end
      end

      S_QRY_C0: begin
        state_next = S_QRY_INIT;
      end

      S_QRY_INIT: begin
        acc_next = c_rd_a;
        if (n == CNT_W'(1)) begin
          res_val_next = c_rd_a;
          res_st_next  = qsat ? ST_SAT : ST_OK;
          state_next   = S_RESULT;
        end else begin
          j_next     = IDX_W'(1);
          state_next = S_QRY_J;
        end
      end

      S_QRY_J: begin
        state_next = S_QRY_JD;
      end

      S_QRY_JD: begin
        term_next  = c_rd_a;
        k_next     = j;
        state_next = S_QRY_RD;
      end

      S_QRY_RD: begin
        state_next = S_QRY_DIF;
      end

      S_QRY_DIF: begin
        qsat_next  = qsat | d_s.sat;
        mul_start  = 1'b1;
        state_next = S_QRY_MUL;
      end

      S_QRY_MUL: begin
        if (mul_done) begin
          term_next = mul_p;
          qsat_next = qsat | mul_sat;
          if (k == IDX_W'(1)) begin
            state_next = S_QRY_ACC;
          end else begin
            k_next     = k - 1'b1;
            state_next = S_QRY_RD;
          end
        end
      end

      S_QRY_ACC: begin
        acc_next = acc_s.value;
        if (j == n_m1) begin
          res_val_next = acc_s.value;
          res_st_next  = (qsat | acc_s.sat) ? ST_SAT : ST_OK;
          state_next   = S_RESULT;
        end else begin
          qsat_next  = qsat | acc_s.sat;
          j_next     = j + 1'b1;
          state_next = S_QRY_J;
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/nwi_checker.sv =====
// port-level checks for the newton interpolator, bound to the top level
// depends on nwi_pkg and newton_interpolator
`timescale 1ns / 1ps

module nwi_checker import nwi_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] interpolated,
  input logic [1:0]        status
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(interpolated) && $stable(status))
    else $error("stalled result changed");

  // error answers carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_READY || status == ST_DIV_ZERO)
      |-> interpolated == '0)
    else $error("error status with nonzero value");

  // after reset the block is idle with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind newton_interpolator nwi_checker u_nwi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .interpolated (interpolated),
  .status       (status)
);
